@@ rtl/dirty_rectangle_difference_core_defines.svh @@
// assertion macros for the dirty rectangle core
// expects signals named clk and rst_n in the scope of use
`ifndef DIRTY_RECTANGLE_DIFFERENCE_CORE_DEFINES_SVH
`define DIRTY_RECTANGLE_DIFFERENCE_CORE_DEFINES_SVH

// same-cycle implication
`define DRD_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define DRD_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/drd_pkg.sv @@
// shared constants and helpers for the dirty rectangle core
// no dependencies
`timescale 1ns / 1ps

package drd_pkg;

    localparam int COORD_BITS_DEFAULT = 10;
    localparam int QUEUE_DEPTH        = 2;

    // area slots of one tile, in issue order
    localparam int NUM_SLOTS   = 5;
    localparam int SLOT_NEW    = 0;
    localparam int SLOT_TOP    = 1; // also carries the whole old rectangle
    localparam int SLOT_LEFT   = 2;
    localparam int SLOT_RIGHT  = 3;
    localparam int SLOT_BOTTOM = 4;
    localparam int SLOT_BITS   = $clog2(NUM_SLOTS);

    // bits of vis_flags
    localparam int FLAG_NEW_VIS = 0;
    localparam int FLAG_OLD_VIS = 1;
    localparam int FLAG_NEVER   = 2;
    localparam int FLAG_BITS    = 3;

    // width of one queue entry: any flag, slot mask, slot rectangles
    function automatic int entry_width(input int cb);
        return 1 + NUM_SLOTS * (1 + 4 * cb);
    endfunction

endpackage

@@ rtl/dirty_rectangle_difference_core.sv @@
// Dirty rectangle redraw region core. For each tile item pushed in, compares the new
// rectangle, colour and visibility with what was drawn last and pops out the areas to
// redraw: one to five per tile, the last one flagged by last_area; a tile that needs
// nothing gives a single result with area_valid low. The front end works out all areas of
// an item in the cycle it is accepted and writes them into a two-entry queue; the back end
// walks the head entry and issues one area per cycle through its single output register,
// as long as each result is popped; an unpopped result holds the register and stalls the
// back end. The first result of an item passes through its queue entry and then that
// output register before it shows on the result ports. A push is taken whenever the queue
// has room, also while results wait to be popped.
// depends on drd_pkg, drd_front, drd_queue, drd_back and the assertion macro header
`timescale 1ns / 1ps

`include "dirty_rectangle_difference_core_defines.svh"

module dirty_rectangle_difference_core #(
    parameter int COORD_BITS = drd_pkg::COORD_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // item input side
    input  logic                          push,
    output logic                          full,
    input  logic [drd_pkg::FLAG_BITS-1:0] vis_flags,
    input  logic [COORD_BITS-1:0]         new_left,
    input  logic [COORD_BITS-1:0]         new_right,
    input  logic [COORD_BITS-1:0]         new_top,
    input  logic [COORD_BITS-1:0]         new_bottom,
    input  logic [COORD_BITS-1:0]         old_left,
    input  logic [COORD_BITS-1:0]         old_right,
    input  logic [COORD_BITS-1:0]         old_top,
    input  logic [COORD_BITS-1:0]         old_bottom,
    input  logic [31:0]                   new_color,
    input  logic [31:0]                   old_color,
    // result side
    output logic                          empty,
    input  logic                          pop,
    output logic                          area_valid,
    output logic [COORD_BITS-1:0]         area_left,
    output logic [COORD_BITS-1:0]         area_right,
    output logic [COORD_BITS-1:0]         area_top,
    output logic [COORD_BITS-1:0]         area_bottom,
    output logic                          last_area
);

    localparam int ENTRY_BITS = drd_pkg::entry_width(COORD_BITS);

    // classified item from the front end
    logic [ENTRY_BITS-1:0] front_entry;
    // head entry seen by the back end
    logic [ENTRY_BITS-1:0] head_entry;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    logic                  accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    // front end: all compares, overlap window and strip corners in one step
    drd_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .vis_flags  (vis_flags),
        .new_left   (new_left),
        .new_right  (new_right),
        .new_top    (new_top),
        .new_bottom (new_bottom),
        .old_left   (old_left),
        .old_right  (old_right),
        .old_top    (old_top),
        .old_bottom (old_bottom),
        .new_color  (new_color),
        .old_color  (old_color),
        .entry      (front_entry)
    );

    // decoupling queue, one entry per tile item
    drd_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (drd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_entry),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (head_entry),
        .q_empty (q_empty)
    );

    // back end: one area per cycle while results are popped, entry retired with its last area
    drd_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_entry),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .area_valid  (area_valid),
        .area_left   (area_left),
        .area_right  (area_right),
        .area_top    (area_top),
        .area_bottom (area_bottom),
        .last_area   (last_area)
    );

    // a null result is always the only, hence last, one of its tile
    `DRD_ASSERT_IMP(a_null_is_last, !empty && !area_valid, last_area, "null area not last")
    // a null result carries zero corners
    `DRD_ASSERT_IMP(a_null_zero, !empty && !area_valid,
        (area_left == '0) && (area_right == '0) && (area_top == '0) && (area_bottom == '0),
        "null area has corners")
    // the back end never retires an entry from an empty queue
    `DRD_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty, "queue read while empty")
    // a retired entry always leaves a result behind in the output register
    `DRD_ASSERT_NXT(a_pop_fills_out, q_pop, !empty && last_area, "retired entry without last area")

endmodule

@@ rtl/drd_front.sv @@
// front end: classifies one tile and works out all its redraw areas
// depends on drd_pkg
`timescale 1ns / 1ps

module drd_front #(
    parameter int COORD_BITS = drd_pkg::COORD_BITS_DEFAULT
) (
    input  logic [drd_pkg::FLAG_BITS-1:0]                vis_flags,
    input  logic [COORD_BITS-1:0]                        new_left,
    input  logic [COORD_BITS-1:0]                        new_right,
    input  logic [COORD_BITS-1:0]                        new_top,
    input  logic [COORD_BITS-1:0]                        new_bottom,
    input  logic [COORD_BITS-1:0]                        old_left,
    input  logic [COORD_BITS-1:0]                        old_right,
    input  logic [COORD_BITS-1:0]                        old_top,
    input  logic [COORD_BITS-1:0]                        old_bottom,
    input  logic [31:0]                                  new_color,
    input  logic [31:0]                                  old_color,
    output logic [drd_pkg::entry_width(COORD_BITS)-1:0]  entry
);

    typedef struct packed {
        logic [COORD_BITS-1:0] l;
        logic [COORD_BITS-1:0] r;
        logic [COORD_BITS-1:0] t;
        logic [COORD_BITS-1:0] b;
    } rect_t;

    typedef struct packed {
        logic                              any;
        logic [drd_pkg::NUM_SLOTS-1:0]     mask;
        rect_t [drd_pkg::NUM_SLOTS-1:0]    slot;
    } entry_t;

    entry_t e;
    rect_t  n;
    rect_t  o;
    logic   nv;
    logic   ov;
    logic   nr;
    logic   moved;
    logic   disjoint;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] x2;
    logic [COORD_BITS-1:0] y1;
    logic [COORD_BITS-1:0] y2;

    always_comb
    begin
        n  = '{l: new_left, r: new_right, t: new_top, b: new_bottom};
        o  = '{l: old_left, r: old_right, t: old_top, b: old_bottom};
        nv = vis_flags[drd_pkg::FLAG_NEW_VIS];
        ov = vis_flags[drd_pkg::FLAG_OLD_VIS];
        nr = vis_flags[drd_pkg::FLAG_NEVER];

        moved    = (n != o);
        disjoint = (n.l > o.r) || (n.r < o.l) || (n.t > o.b) || (n.b < o.t);

        // overlap window
        x1 = (n.l > o.l) ? n.l : o.l;
        x2 = (n.r < o.r) ? n.r : o.r;
        y1 = (n.t > o.t) ? n.t : o.t;
        y2 = (n.b < o.b) ? n.b : o.b;

        e      = '0;
        e.mask = '0;

        if (!nv && !ov && !nr)
        begin
            e.any = 1'b0;
        end
        else if ((nv && !ov) || nr)
        begin
            e.any                        = 1'b1;
            e.mask[drd_pkg::SLOT_NEW]    = 1'b1;
            e.slot[drd_pkg::SLOT_NEW]    = n;
        end
        else if (!nv && ov)
        begin
            e.any                        = 1'b1;
            e.mask[drd_pkg::SLOT_NEW]    = 1'b1;
            e.slot[drd_pkg::SLOT_NEW]    = o;
        end
        else if (moved)
        begin
            e.any                        = 1'b1;
            e.mask[drd_pkg::SLOT_NEW]    = 1'b1;
            e.slot[drd_pkg::SLOT_NEW]    = n;
            if (disjoint)
            begin
                e.mask[drd_pkg::SLOT_TOP] = 1'b1;
                e.slot[drd_pkg::SLOT_TOP] = o;
            end
            else
            begin
                e.mask[drd_pkg::SLOT_TOP]    = (o.t < y1);
                e.slot[drd_pkg::SLOT_TOP]    = '{l: o.l, r: o.r, t: o.t, b: y1 - 1'b1};
                e.mask[drd_pkg::SLOT_LEFT]   = (o.l < x1);
                e.slot[drd_pkg::SLOT_LEFT]   = '{l: o.l, r: x1 - 1'b1, t: y1, b: y2};
                e.mask[drd_pkg::SLOT_RIGHT]  = (o.r > x2);
                e.slot[drd_pkg::SLOT_RIGHT]  = '{l: x2 + 1'b1, r: o.r, t: y1, b: y2};
                e.mask[drd_pkg::SLOT_BOTTOM] = (o.b > y2);
                e.slot[drd_pkg::SLOT_BOTTOM] = '{l: o.l, r: o.r, t: y2 + 1'b1, b: o.b};
            end
        end
        else if (new_color != old_color)
        begin
            e.any                        = 1'b1;
            e.mask[drd_pkg::SLOT_NEW]    = 1'b1;
            e.slot[drd_pkg::SLOT_NEW]    = n;
        end

        // nothing to redraw: one null area in the first slot
        if (!e.any)
        begin
            e.mask                    = '0;
            e.mask[drd_pkg::SLOT_NEW] = 1'b1;
            e.slot                    = '0;
        end

        entry = e;
    end

endmodule

@@ rtl/drd_queue.sv @@
// short register queue between front and back end
// depends on drd_pkg
`timescale 1ns / 1ps

module drd_queue #(
    parameter int WIDTH = drd_pkg::entry_width(drd_pkg::COORD_BITS_DEFAULT),
    parameter int DEPTH = drd_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             q_full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             q_empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0]    entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [PTR_BITS:0]   count_reg;
    logic [PTR_BITS:0]   count_next;

    function automatic logic [PTR_BITS-1:0] bump(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign q_full  = (count_reg == (PTR_BITS + 1)'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd_en ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/drd_back.sv @@
// back end: issues the areas of the head entry one per cycle while results are popped
// depends on drd_pkg
`timescale 1ns / 1ps

module drd_back #(
    parameter int COORD_BITS = drd_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic [drd_pkg::entry_width(COORD_BITS)-1:0] head,
    input  logic                                        q_empty,
    output logic                                        q_pop,
    output logic                                        empty,
    input  logic                                        pop,
    output logic                                        area_valid,
    output logic [COORD_BITS-1:0]                       area_left,
    output logic [COORD_BITS-1:0]                       area_right,
    output logic [COORD_BITS-1:0]                       area_top,
    output logic [COORD_BITS-1:0]                       area_bottom,
    output logic                                        last_area
);

    typedef struct packed {
        logic [COORD_BITS-1:0] l;
        logic [COORD_BITS-1:0] r;
        logic [COORD_BITS-1:0] t;
        logic [COORD_BITS-1:0] b;
    } rect_t;

    typedef struct packed {
        logic                              any;
        logic [drd_pkg::NUM_SLOTS-1:0]     mask;
        rect_t [drd_pkg::NUM_SLOTS-1:0]    slot;
    } entry_t;

    entry_t                            h;
    logic [drd_pkg::NUM_SLOTS-1:0]     sent_reg;
    logic [drd_pkg::NUM_SLOTS-1:0]     sent_next;
    logic [drd_pkg::NUM_SLOTS-1:0]     remaining;
    logic [drd_pkg::NUM_SLOTS-1:0]     pick;
    logic [drd_pkg::SLOT_BITS-1:0]     sel;
    logic                              load;
    logic                              is_last;
    logic                              out_vld_reg;
    logic                              out_vld_next;
    rect_t                             area_reg;
    logic                              any_reg;
    logic                              last_reg;

    always_comb
    begin
        h         = entry_t'(head);
        remaining = h.mask & ~sent_reg;
        sel       = '0;
        for (int i = drd_pkg::NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (remaining[i])
            begin
                sel = drd_pkg::SLOT_BITS'(i);
            end
        end
        pick    = drd_pkg::NUM_SLOTS'(1) << sel;
        is_last = ((remaining & ~pick) == '0);

        // output register free or being emptied this cycle
        load  = !q_empty && (!out_vld_reg || pop);
        q_pop = load && is_last;

        sent_next = sent_reg;
        if (load)
        begin
            sent_next = is_last ? '0 : (sent_reg | pick);
        end

        out_vld_next = out_vld_reg;
        if (load)
        begin
            out_vld_next = 1'b1;
        end
        else if (pop)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            sent_reg    <= sent_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            area_reg <= h.slot[sel];
            any_reg  <= h.any;
            last_reg <= is_last;
        end
    end

    assign empty       = !out_vld_reg;
    assign area_valid  = any_reg;
    assign area_left   = area_reg.l;
    assign area_right  = area_reg.r;
    assign area_top    = area_reg.t;
    assign area_bottom = area_reg.b;
    assign last_area   = last_reg;

endmodule
